@@ hdl/ccsm_pkg.sv @@
// shared types and codes for the crate cycle sync master
`timescale 1ns / 1ps
package ccsm_pkg;

  // request codes
  localparam logic [2:0] REQ_BEGIN     = 3'd0;
  localparam logic [2:0] REQ_READY     = 3'd1;
  localparam logic [2:0] REQ_STOP      = 3'd2;
  localparam logic [2:0] REQ_EOC       = 3'd3;
  localparam logic [2:0] REQ_POLL_LIVE = 3'd4;
  localparam logic [2:0] REQ_POLL_DEAD = 3'd5;

  // result codes
  localparam logic [2:0] KIND_ACK     = 3'd0;
  localparam logic [2:0] KIND_STOP    = 3'd1;
  localparam logic [2:0] KIND_START   = 3'd2;
  localparam logic [2:0] KIND_STALE   = 3'd3;
  localparam logic [2:0] KIND_NOTICE  = 3'd4;
  localparam logic [2:0] KIND_CLOSED  = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_OWN          = 2'd0;
  localparam logic [1:0] CFG_ENABLE       = 2'd1;
  localparam logic [1:0] CFG_ENABLED_MASK = 2'd2;
  localparam logic [1:0] CFG_SYNC_MASK    = 2'd3;

  // ram slots
  localparam logic [1:0] RAM_ANY  = 2'd0;
  localparam logic [1:0] RAM_ODD  = 2'd1;
  localparam logic [1:0] RAM_EVEN = 2'd2;

  localparam logic [30:0] EVENT_FIRST = 31'd1;

  // queue depths
  localparam int JQ_DEPTH = 4;
  localparam int OQ_DEPTH = 2;

  typedef struct packed {
    logic [2:0] own_crate;
    logic       master_enable;
    logic [7:0] enabled_mask;
    logic [7:0] sync_mask;
  } cfg_t;

  // one classified request on its way to the back end
  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  ram;
    logic [30:0] ev;
    logic [7:0]  part;
    logic [7:0]  notify;
  } job_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  target;
    logic [1:0]  ram;
    logic [30:0] ev;
    logic [7:0]  part;
    logic        last;
  } result_t;

endpackage

@@ hdl/ccsm_front.sv @@
// request classifier and barrier state
`timescale 1ns / 1ps
module ccsm_front #(
  parameter int NUM_CRATES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  ccsm_pkg::cfg_t    cfg,
  input  logic              in_valid,
  input  logic [2:0]        req_type,
  input  logic [2:0]        crate_id,
  input  logic [1:0]        ram_select,
  input  logic [30:0]       event_in,
  output ccsm_pkg::job_t    job,
  output logic              job_valid
);
  import ccsm_pkg::*;

  localparam logic [7:0] LIVE_CRATES =
    (NUM_CRATES >= 8) ? 8'hFF : 8'((1 << NUM_CRATES) - 1);

  logic [7:0]  ready_flags [0:2];
  logic [7:0]  ready_flags_next [0:2];
  logic [7:0]  participating_mask;
  logic [7:0]  participating_mask_next;
  logic [30:0] event_count;
  logic [30:0] event_count_next;
  logic [30:0] stop_request_event;
  logic [30:0] stop_request_event_next;

  logic [1:0]  ram_cur;
  logic [7:0]  live_others;
  logic [7:0]  have;
  logic [7:0]  need;

  assign job_valid = in_valid;

  // classify the word and work out the state it leaves
  always_comb begin
    ready_flags_next        = ready_flags;
    participating_mask_next = participating_mask;
    event_count_next        = event_count;
    stop_request_event_next = stop_request_event;

    ram_cur     = event_count[0] ? RAM_ODD : RAM_EVEN;
    live_others = LIVE_CRATES & ~(8'b1 << cfg.own_crate);
    have        = ready_flags[ram_cur] | ready_flags[RAM_ANY];
    need        = live_others & cfg.enabled_mask & cfg.sync_mask;

    job.kind   = KIND_ACK;
    job.ram    = RAM_ANY;
    job.ev     = event_count;
    job.part   = participating_mask;
    job.notify = 8'h00;

    if (cfg.master_enable) begin
      case (req_type)
        REQ_BEGIN: begin
          ready_flags_next[0]     = 8'h00;
          ready_flags_next[1]     = 8'h00;
          ready_flags_next[2]     = 8'h00;
          event_count_next        = EVENT_FIRST;
          stop_request_event_next = 31'd0;
        end
        REQ_READY: begin
          if (ram_select != 2'd3 && LIVE_CRATES[crate_id]) begin
            ready_flags_next[ram_select] = ready_flags[ram_select] | (8'b1 << crate_id);
          end
        end
        REQ_STOP: begin
          if (event_in == event_count) begin
            stop_request_event_next = event_in;
          end else begin
            job.kind = KIND_STALE;
          end
        end
        REQ_EOC: begin
          job.kind   = KIND_CLOSED;
          job.ram    = ram_cur;
          job.notify = live_others & cfg.enabled_mask
                       & (cfg.sync_mask | participating_mask);
          event_count_next = event_count + 31'd1;
        end
        REQ_POLL_LIVE: begin
          if (stop_request_event == event_count) begin
            job.kind = KIND_STOP;
          end
        end
        REQ_POLL_DEAD: begin
          if ((need & ~have) == 8'h00) begin
            participating_mask_next    = have & LIVE_CRATES;
            ready_flags_next[ram_cur]  = 8'h00;
            ready_flags_next[RAM_ANY]  = 8'h00;
            job.kind = KIND_START;
            job.ram  = ram_cur;
            job.part = have & LIVE_CRATES;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // state update on an accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      ready_flags[0]     <= 8'h00;
      ready_flags[1]     <= 8'h00;
      ready_flags[2]     <= 8'h00;
      participating_mask <= 8'h00;
      event_count        <= EVENT_FIRST;
      stop_request_event <= 31'd0;
    end else if (in_valid) begin
      ready_flags        <= ready_flags_next;
      participating_mask <= participating_mask_next;
      event_count        <= event_count_next;
      stop_request_event <= stop_request_event_next;
    end
  end

endmodule

@@ hdl/ccsm_job_queue.sv @@
// short queue of classified requests between front and back
`timescale 1ns / 1ps
module ccsm_job_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ccsm_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output ccsm_pkg::job_t head,
  output logic           empty
);
  import ccsm_pkg::*;

  localparam int PW = $clog2(JQ_DEPTH);

  job_t        mem [0:JQ_DEPTH-1];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == (PW+1)'(JQ_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_job;
  end

endmodule

@@ hdl/ccsm_back.sv @@
// result generator: expands end of cycle into notices, buffers results
`timescale 1ns / 1ps
module ccsm_back (
  input  logic              clk,
  input  logic              rst,
  input  ccsm_pkg::job_t    jq_head,
  input  logic              jq_empty,
  output logic              jq_pop,
  input  logic              pop,
  output ccsm_pkg::result_t res,
  output logic              res_empty
);
  import ccsm_pkg::*;

  localparam int OPW = $clog2(OQ_DEPTH);

  logic       busy;
  job_t       cur;
  logic [7:0] remaining;

  result_t          oq [0:OQ_DEPTH-1];
  logic [OPW-1:0]   oq_wr;
  logic [OPW-1:0]   oq_rd;
  logic [OPW:0]     oq_count;
  logic             oq_full;
  logic             oq_pop;

  logic       emit;
  logic       notice_now;
  logic [2:0] low_idx;
  result_t    emit_res;

  assign oq_full   = (oq_count == (OPW+1)'(OQ_DEPTH));
  assign res_empty = (oq_count == '0);
  assign oq_pop    = pop && !res_empty;
  assign res       = oq[oq_rd];

  assign jq_pop     = !busy && !jq_empty;
  assign emit       = busy && !oq_full;
  assign notice_now = (cur.kind == KIND_CLOSED) && (remaining != 8'h00);

  // lowest crate still to be notified
  always_comb begin
    low_idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (remaining[i]) low_idx = 3'(i);
    end
  end

  // result word for this cycle
  always_comb begin
    emit_res.ram  = cur.ram;
    emit_res.ev   = cur.ev;
    emit_res.part = cur.part;
    if (notice_now) begin
      emit_res.kind   = KIND_NOTICE;
      emit_res.target = low_idx;
      emit_res.last   = 1'b0;
    end else begin
      emit_res.kind   = cur.kind;
      emit_res.target = 3'd0;
      emit_res.last   = 1'b1;
    end
  end

  // job sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (jq_pop) begin
      busy <= 1'b1;
    end else if (emit && !notice_now) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (jq_pop) begin
      cur       <= jq_head;
      remaining <= jq_head.notify;
    end else if (emit && notice_now) begin
      remaining <= remaining & (remaining - 8'd1);
    end
  end

  // output queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= '0;
      oq_rd    <= '0;
      oq_count <= '0;
    end else begin
      if (emit) oq_wr <= oq_wr + 1'b1;
      if (oq_pop) oq_rd <= oq_rd + 1'b1;
      if (emit && !oq_pop) begin
        oq_count <= oq_count + 1'b1;
      end else if (oq_pop && !emit) begin
        oq_count <= oq_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) oq[oq_wr] <= emit_res;
  end

endmodule

@@ hdl/crate_cycle_sync_master.sv @@
// top level of the crate cycle sync master
`timescale 1ns / 1ps
// Barrier master for readout crates. Requests enter through a queue-like
// push/full port; the front end classifies each word and updates the ready
// flags, participation mask, event counter and stop event in the cycle it is
// accepted, then places a job in a four-deep queue. The back end turns each
// job into results one per cycle, while its two-word output queue (read with
// empty/pop) has room. A new job is taken only after the last result of
// the current one is written; end of cycle gives a notice per crate notified
// (at most 7) before the close, so the back end's sequencer, at one result
// per cycle, sets the sustained rate. Configuration is written through
// cfg_valid/cfg_ready (always ready) and must only change while idle.
module crate_cycle_sync_master #(
  parameter int NUM_CRATES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  req_type,
  input  logic [2:0]  crate_id,
  input  logic [1:0]  ram_select,
  input  logic [30:0] event_in,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind,
  output logic [2:0]  target_crate,
  output logic [1:0]  ram_out,
  output logic [30:0] event_out,
  output logic [7:0]  participating_out,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import ccsm_pkg::*;

  cfg_t    cfg;
  logic    in_valid;
  job_t    front_job;
  logic    front_valid;
  job_t    jq_head;
  logic    jq_empty;
  logic    jq_pop;
  result_t res;

  assign cfg_ready = 1'b1;
  assign in_valid  = push && !full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OWN:          cfg.own_crate     <= cfg_data[2:0];
        CFG_ENABLE:       cfg.master_enable <= cfg_data[0];
        CFG_ENABLED_MASK: cfg.enabled_mask  <= cfg_data;
        CFG_SYNC_MASK:    cfg.sync_mask     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ccsm_front #(
    .NUM_CRATES(NUM_CRATES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .req_type   (req_type),
    .crate_id   (crate_id),
    .ram_select (ram_select),
    .event_in   (event_in),
    .job        (front_job),
    .job_valid  (front_valid)
  );

  ccsm_job_queue u_job_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (front_valid),
    .push_job (front_job),
    .full     (full),
    .pop      (jq_pop),
    .head     (jq_head),
    .empty    (jq_empty)
  );

  ccsm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .jq_head   (jq_head),
    .jq_empty  (jq_empty),
    .jq_pop    (jq_pop),
    .pop       (pop),
    .res       (res),
    .res_empty (empty)
  );

  assign kind              = res.kind;
  assign target_crate      = res.target;
  assign ram_out           = res.ram;
  assign event_out         = res.ev;
  assign participating_out = res.part;
  assign last              = res.last;

  // only notices are followed by more words of the same request
  a_notice_not_last: assert property (@(posedge clk) disable iff (rst)
    !empty && !last |-> kind == KIND_NOTICE)
    else $error("non-final word is not a cycle notice");

  a_notice_is_not_last: assert property (@(posedge clk) disable iff (rst)
    !empty && kind == KIND_NOTICE |-> !last)
    else $error("cycle notice marked final");

  // slot carried by notices, closes and starts follows the event parity
  a_ram_parity: assert property (@(posedge clk) disable iff (rst)
    !empty && (kind == KIND_NOTICE || kind == KIND_CLOSED || kind == KIND_START)
    |-> ram_out == (event_out[0] ? RAM_ODD : RAM_EVEN))
    else $error("ram slot does not match event parity");

endmodule

@@ test/tb_crate_cycle_sync_master.sv @@
// testbench for the crate cycle sync master: directed and random requests, checked word by word
`timescale 1ns / 1ps
module tb_crate_cycle_sync_master;
  import ccsm_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 12;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  req_type = '0;
  logic [2:0]  crate_id = '0;
  logic [1:0]  ram_select = '0;
  logic [30:0] event_in = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  kind;
  logic [2:0]  target_crate;
  logic [1:0]  ram_out;
  logic [30:0] event_out;
  logic [7:0]  participating_out;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  // copy of the master's configuration and state
  logic [2:0]  own_m = '0;
  logic        enable_m = 1'b0;
  logic [7:0]  emask_m = '0;
  logic [7:0]  smask_m = '0;
  logic [7:0]  flags_m [0:2] = '{default: '0};
  logic [7:0]  part_m = '0;
  logic [30:0] event_m = EVENT_FIRST;
  logic [30:0] stop_m = '0;

  result_t pending_answers [$];
  int requests_sent = 0;
  int answers_seen = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int tx_idle_pct = 38;
  int rx_idle_pct = 59;

  crate_cycle_sync_master u_top (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .req_type(req_type),
    .crate_id(crate_id),
    .ram_select(ram_select),
    .event_in(event_in),
    .empty(empty),
    .pop(pop),
    .kind(kind),
    .target_crate(target_crate),
    .ram_out(ram_out),
    .event_out(event_out),
    .participating_out(participating_out),
    .last(last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // expected answers for one accepted request, state updated as the master does
  function automatic void predict_answers(logic [2:0] rq, logic [2:0] cid, logic [1:0] sel,
                                          logic [30:0] evin);
    logic [30:0] ev;
    logic [1:0]  slot;
    logic [7:0]  others;
    logic [7:0]  who;
    logic [7:0]  have;
    logic [7:0]  need;
    result_t     r;
    ev = event_m;
    slot = ev[0] ? RAM_ODD : RAM_EVEN;
    others = ~(8'd1 << own_m);
    r = '0;
    r.kind = KIND_ACK;
    r.ev = ev;
    r.last = 1'b1;
    // disabled master and unused kinds only get an ack
    if (enable_m && rq <= REQ_POLL_DEAD) begin
      case (rq)
        REQ_BEGIN: begin
          foreach (flags_m[s]) flags_m[s] = '0;
          event_m = EVENT_FIRST;
          stop_m = '0;
        end
        REQ_READY: begin
          if (sel <= RAM_EVEN) flags_m[sel][cid] = 1'b1;
        end
        REQ_STOP: begin
          if (evin == ev) stop_m = evin;
          else r.kind = KIND_STALE;
        end
        REQ_EOC: begin
          who = others & emask_m & (smask_m | part_m);
          for (int i = 0; i < 8; i++) begin
            if (who[i]) begin
              r.kind = KIND_NOTICE;
              r.target = i[2:0];
              r.ram = slot;
              r.part = part_m;
              r.last = 1'b0;
              pending_answers.push_back(r);
            end
          end
          r.kind = KIND_CLOSED;
          r.target = '0;
          r.ram = slot;
          r.last = 1'b1;
          event_m = ev + 31'd1;
        end
        REQ_POLL_LIVE: begin
          if (stop_m == ev) r.kind = KIND_STOP;
        end
        default: begin
          have = flags_m[slot] | flags_m[RAM_ANY];
          need = others & emask_m & smask_m;
          if ((need & ~have) == 8'd0) begin
            part_m = have;
            flags_m[slot] = '0;
            flags_m[RAM_ANY] = '0;
            r.kind = KIND_START;
            r.ram = slot;
          end
        end
      endcase
    end
    r.part = part_m;
    pending_answers.push_back(r);
  endfunction

  function automatic logic [30:0] rand_event();
    logic [31:0] w;
    w = $urandom;
    return w[30:0];
  endfunction

  // one request word through the push/full port
  task automatic send_request(logic [2:0] rq, logic [2:0] cid, logic [1:0] sel,
                              logic [30:0] evin);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    req_type <= rq;
    crate_id <= cid;
    ram_select <= sel;
    event_in <= evin;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_answers(rq, cid, sel, evin);
    requests_sent++;
  endtask

  task automatic send_noise();
    send_request(3'($urandom_range(7)), 3'($urandom_range(7)), 2'($urandom_range(3)),
                 rand_event());
  endtask

  // hold off the sender until every answer is back and the back end has settled
  task automatic wait_for_results();
    push <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // one register word; valid stays up for the next one
  task automatic cfg_write(logic [1:0] index, logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      CFG_OWN:          own_m = value[2:0];
      CFG_ENABLE:       enable_m = value[0];
      CFG_ENABLED_MASK: emask_m = value;
      default:          smask_m = value;
    endcase
  endtask

  task automatic write_config(logic [2:0] own, logic en, logic [7:0] emask, logic [7:0] smask);
    wait_for_results();
    cfg_write(CFG_OWN, {5'd0, own});
    cfg_write(CFG_ENABLE, {7'd0, en});
    cfg_write(CFG_ENABLED_MASK, emask);
    cfg_write(CFG_SYNC_MASK, smask);
    cfg_valid <= 1'b0;
  endtask

  // a well-formed barrier cycle with random content and some noise
  task automatic random_cycle();
    logic [1:0] slot;
    if ($urandom_range(7) == 0)
      send_request(REQ_BEGIN, 3'($urandom_range(7)), RAM_ANY, rand_event());
    slot = event_m[0] ? RAM_ODD : RAM_EVEN;
    for (int i = 0; i < 8; i++) begin
      if (smask_m[i] ? ($urandom_range(5) != 0) : ($urandom_range(3) == 0))
        send_request(REQ_READY, i[2:0],
                     ($urandom_range(4) == 0) ? (slot ^ 2'b11) :
                     ($urandom_range(2) == 0) ? RAM_ANY : slot, rand_event());
      if ($urandom_range(9) == 0) send_noise();
    end
    if ($urandom_range(1) != 0)
      send_request(REQ_STOP, 3'($urandom_range(7)), 2'($urandom_range(3)),
                   ($urandom_range(2) != 0) ? event_m : rand_event());
    send_request(REQ_POLL_LIVE, 3'($urandom_range(7)), 2'($urandom_range(3)), rand_event());
    send_request(REQ_POLL_DEAD, 3'($urandom_range(7)), 2'($urandom_range(3)), rand_event());
    send_request(REQ_EOC, 3'($urandom_range(7)), 2'($urandom_range(3)), rand_event());
  endtask

  // reset state: master disabled, everything answered with an ack
  task automatic test_master_disabled();
    send_request(REQ_EOC, 3'd0, RAM_ANY, '0);
    send_request(REQ_STOP, 3'd7, RAM_EVEN, EVENT_FIRST);
    send_request(REQ_POLL_DEAD, 3'd0, RAM_ANY, '1);
  endtask

  // one full barrier sequence by hand, with stale stops and ignored readies
  task automatic test_directed_cycle();
    write_config(3'd3, 1'b1, 8'hFF, 8'b0000_0110);
    send_request(REQ_BEGIN, 3'd0, RAM_ANY, '0);
    send_request(REQ_POLL_DEAD, 3'd0, RAM_ANY, '0);
    send_request(REQ_READY, 3'd1, RAM_ODD, '0);
    send_request(REQ_READY, 3'd2, RAM_ANY, '0);
    // out of range slot is ignored
    send_request(REQ_READY, 3'd7, 2'b11, '0);
    send_request(REQ_READY, 3'd5, RAM_EVEN, '0);
    send_request(REQ_POLL_DEAD, 3'd0, RAM_ANY, '0);
    send_request(REQ_POLL_LIVE, 3'd0, RAM_ANY, '0);
    send_request(REQ_STOP, 3'd4, RAM_ANY, 31'd5);
    send_request(REQ_STOP, 3'd4, RAM_ANY, '1);
    send_request(REQ_STOP, 3'd4, RAM_ANY, '0);
    send_request(REQ_STOP, 3'd6, RAM_ANY, event_m);
    send_request(REQ_POLL_LIVE, 3'd0, RAM_ANY, '0);
    send_request(REQ_EOC, 3'd0, RAM_ANY, '0);
    send_request(REQ_POLL_LIVE, 3'd0, RAM_ANY, '0);
    // unused request kinds
    send_request(3'd6, 3'd2, RAM_ODD, '1);
    send_request(3'd7, 3'd5, 2'b11, '0);
    // own crate ready but a synchronous crate missing
    send_request(REQ_READY, 3'd3, RAM_EVEN, '0);
    send_request(REQ_READY, 3'd1, RAM_EVEN, '0);
    send_request(REQ_POLL_DEAD, 3'd0, RAM_ANY, '0);
    send_request(REQ_READY, 3'd2, RAM_EVEN, '0);
    send_request(REQ_POLL_DEAD, 3'd0, RAM_ANY, '0);
    send_request(REQ_EOC, 3'd0, RAM_ANY, '0);
    send_request(REQ_BEGIN, 3'd0, RAM_ANY, '0);
  endtask

  // own crate and masks at their extremes, master switched off mid-run
  task automatic test_config_extremes();
    write_config(3'd0, 1'b1, 8'h00, 8'h00);
    random_cycle();
    write_config(3'd7, 1'b1, 8'hFF, 8'hFF);
    random_cycle();
    write_config(3'd0, 1'b0, 8'hFF, 8'hFF);
    random_cycle();
    write_config(3'd7, 1'b1, 8'hFF, 8'h00);
    random_cycle();
  endtask

  task automatic random_phase(int tx_pct, int rx_pct, int count);
    int first;
    logic [7:0] emask;
    wait_for_results();
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    emask = 8'($urandom_range(255));
    write_config(3'($urandom_range(7)), $urandom_range(5) != 0,
                 emask | 8'($urandom_range(255)), emask & 8'($urandom_range(255)));
    first = requests_sent;
    while (requests_sent - first < count / 2) random_cycle();
    // sender pauses until the queue has drained
    wait_for_results();
    while (requests_sent - first < count) random_cycle();
  endtask

  task automatic test_random_traffic();
    random_phase(38, 59, 12);
    random_phase(59, 38, 12);
    random_phase(0, 0, 12);
  endtask

  task automatic check_field(string name, logic [30:0] want, logic [30:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // answer checker and receiver stalls
  always @(posedge clk) begin : answer_check
    result_t want;
    if (!rst && pop && !empty) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        mismatches++;
        $display("%0t: answer with nothing expected, expected none, actual kind %0d", $time,
                 kind);
      end else begin
        want = pending_answers.pop_front();
        check_field("kind", want.kind, kind);
        check_field("target_crate", want.target, target_crate);
        check_field("ram_out", want.ram, ram_out);
        check_field("event_out", want.ev, event_out);
        check_field("participating_out", want.part, participating_out);
        check_field("last", want.last, last);
      end
    end
    pop <= ($urandom_range(99) >= rx_idle_pct);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_master_disabled();
    test_directed_cycle();
    test_config_extremes();
    test_random_traffic();
    wait_for_results();
    $display("%0d requests and %0d answer words checked, %0d mismatches", requests_sent,
             answers_seen, mismatches);
    $display("covered disabled master, hand-made barrier cycle, mask extremes, random cycles");
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
